@@ design/substring_delimiter_splitter_core_assert.svh @@
// Assertion macros for the substring delimiter splitter.
// Used by the port checker; needs clk and rst in scope.
`ifndef SUBSTRING_DELIMITER_SPLITTER_CORE_ASSERT_SVH
`define SUBSTRING_DELIMITER_SPLITTER_CORE_ASSERT_SVH

// checked outside reset
`define SDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sds_pkg.sv @@
// Shared types and constants of the substring delimiter splitter.
// No dependencies.
`timescale 1ns / 1ps

package sds_pkg;

  localparam int KIND_W = 2;
  localparam int CNT_W  = 16;
  localparam int NB_W   = 4;
  localparam int OUT_MAX = 9;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SEP_PATTERN = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SEP_LENGTH  = 1'b1;

  localparam logic [63:0] SEP_PATTERN_RESET = 64'd44;
  localparam logic [3:0]  SEP_LENGTH_RESET  = 4'd1;

  typedef struct packed {
    logic [NB_W-1:0]  nbytes;
    logic             tok_end;
    logic             done;
    logic [CNT_W-1:0] count;
  } cmd_ctrl_t;

endpackage

@@ design/sds_front.sv @@
// Front end: config registers, separator matching and token bookkeeping.
// Turns each item into at most one command for the back end. Uses sds_pkg.
`timescale 1ns / 1ps

module sds_front #(
  parameter int MAX_SEP = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [sds_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          has_byte,
  input  logic                          end_of_string,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [MAX_SEP*8-1:0]          q_bytes,
  output sds_pkg::cmd_ctrl_t            q_ctrl
);

  logic [63:0] sep_pattern;
  logic [3:0]  sep_length;
  logic [7:0]  window [MAX_SEP];
  logic [3:0]  held;
  logic        token_open;
  logic [sds_pkg::CNT_W-1:0] tokens_seen;

  logic [3:0]  len_eff;
  logic [7:0]  w [MAX_SEP];
  logic [7:0]  window_next [MAX_SEP];
  logic [MAX_SEP:0] ok;
  logic [3:0]  m;
  logic [3:0]  kk;
  logic [3:0]  rem;
  logic        match;
  logic        open_mid;
  logic        open_fin;
  logic        inc;
  logic        tok_end;
  logic [3:0]  nbytes;
  logic [sds_pkg::CNT_W-1:0] tokens_next;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (sep_length == 4'd0) begin
      len_eff = 4'd1;
    end else if (sep_length > 4'(MAX_SEP)) begin
      len_eff = 4'(MAX_SEP);
    end else begin
      len_eff = sep_length;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SEP; i++) begin
      w[i] = (has_byte && held == 4'(i)) ? in_byte : window[i];
    end
    m = has_byte ? held + 4'd1 : held;
    // ok[k]: dropping k leading bytes leaves a separator prefix
    for (int k = 0; k <= MAX_SEP; k++) begin
      ok[k] = (int'(m) - k) <= int'(len_eff);
      for (int j = 0; j < MAX_SEP - k; j++) begin
        if (k + j < int'(m) && w[k+j] != sep_pattern[8*j +: 8]) begin
          ok[k] = 1'b0;
        end
      end
    end
    kk = m;
    for (int k = MAX_SEP; k >= 0; k--) begin
      if (ok[k]) begin
        kk = 4'(k);
      end
    end
    rem = m - kk;
    for (int i = 0; i < MAX_SEP; i++) begin
      window_next[i] = w[i];
      for (int s = 0; s < MAX_SEP - i; s++) begin
        if (kk == 4'(s)) begin
          window_next[i] = w[i+s];
        end
      end
    end
  end

  always_comb begin
    match    = has_byte && rem == len_eff;
    open_mid = token_open || kk != 4'd0;
    open_fin = has_byte ? 1'b1 : (token_open || held != 4'd0);
    if (match) begin
      nbytes  = kk;
      inc     = open_mid;
      tok_end = open_mid;
    end else begin
      nbytes  = end_of_string ? m : (has_byte ? kk : 4'd0);
      inc     = end_of_string && open_fin;
      tok_end = end_of_string && open_fin && (5'(m) + 5'd2 <= 5'(sds_pkg::OUT_MAX));
    end
    tokens_next = (inc && tokens_seen != '1) ? tokens_seen + sds_pkg::CNT_W'(1) : tokens_seen;
  end

  always_comb begin
    for (int i = 0; i < MAX_SEP; i++) begin
      q_bytes[8*i +: 8] = w[i];
    end
    q_ctrl.nbytes  = nbytes;
    q_ctrl.tok_end = tok_end;
    q_ctrl.done    = end_of_string;
    q_ctrl.count   = end_of_string ? tokens_next : '0;
    q_push = accept && (nbytes != 4'd0 || tok_end || end_of_string);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_pattern <= sds_pkg::SEP_PATTERN_RESET;
      sep_length  <= sds_pkg::SEP_LENGTH_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        sds_pkg::REG_SEP_PATTERN: sep_pattern <= cfg_data;
        sds_pkg::REG_SEP_LENGTH:  sep_length  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 4'd0;
      token_open  <= 1'b0;
      tokens_seen <= '0;
    end else if (accept) begin
      if (end_of_string) begin
        held        <= 4'd0;
        token_open  <= 1'b0;
        tokens_seen <= '0;
      end else if (has_byte) begin
        tokens_seen <= tokens_next;
        if (match) begin
          held       <= 4'd0;
          token_open <= 1'b0;
        end else begin
          held       <= rem;
          token_open <= open_mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_byte && !end_of_string && !match) begin
      for (int i = 0; i < MAX_SEP; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

endmodule

@@ design/sds_queue.sv @@
// Two-entry command queue between front and back end.
// Generic data width; no package use.
`timescale 1ns / 1ps

module sds_queue #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  logic [DW-1:0] mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ design/sds_back.sv @@
// Back end: plays one command out as token bytes, token end and done items
// through a registered output stage. Uses sds_pkg.
`timescale 1ns / 1ps

module sds_back #(
  parameter int MAX_SEP = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [MAX_SEP*8-1:0]         q_bytes,
  input  sds_pkg::cmd_ctrl_t           q_ctrl,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [sds_pkg::KIND_W-1:0]   m_kind,
  output logic [7:0]                   m_byte,
  output logic [sds_pkg::CNT_W-1:0]    m_count,
  output logic                         m_last
);

  localparam int IW = (MAX_SEP > 1) ? $clog2(MAX_SEP) : 1;

  logic                 cur_valid;
  logic [MAX_SEP*8-1:0] cur_bytes;
  sds_pkg::cmd_ctrl_t   cur_ctrl;
  logic [3:0]           r;

  logic                       out_free;
  logic                       emit;
  logic                       last;
  logic [3:0]                 total;
  logic [IW-1:0]              idx;
  logic [sds_pkg::KIND_W-1:0] kind;

  always_comb begin
    out_free = !m_valid || m_ready;
    emit     = cur_valid && out_free;
    total    = cur_ctrl.nbytes + 4'(cur_ctrl.tok_end) + 4'(cur_ctrl.done);
    last     = r == total - 4'd1;
    q_pop    = !q_empty && (!cur_valid || (emit && last));
    idx      = r[IW-1:0];
    if (r < cur_ctrl.nbytes) begin
      kind = sds_pkg::KIND_BYTE;
    end else if (r == cur_ctrl.nbytes && cur_ctrl.tok_end) begin
      kind = sds_pkg::KIND_END;
    end else begin
      kind = sds_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      r         <= 4'd0;
      m_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        r         <= 4'd0;
      end else if (emit && last) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        r <= r + 4'd1;
      end
      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bytes <= q_bytes;
      cur_ctrl  <= q_ctrl;
    end
    if (emit) begin
      m_kind  <= kind;
      m_byte  <= (kind == sds_pkg::KIND_BYTE) ? cur_bytes[8*idx +: 8] : 8'd0;
      m_count <= (kind == sds_pkg::KIND_DONE) ? cur_ctrl.count : '0;
      m_last  <= last;
    end
  end

endmodule

@@ design/substring_delimiter_splitter_core.sv @@
// Top level of the substring delimiter splitter: front end, command queue,
// back end. Uses sds_pkg, sds_front, sds_queue, sds_back.
//
//   channel  dir  tdata                         tuser      tlast
//   s_axis   in   [7:0] in_byte                 has_byte   end_of_string
//   m_axis   out  [7:0] out_byte, [23:8] count  kind       run_last
//   cfg      in   cfg_data, cfg_index 0 pattern / 1 length, cfg_en
//
// Input takes one item per cycle while the two-entry command queue has room.
// Output gives one item per cycle unless stalled; an input item yields 0 to 9
// output items, so the sustained rate is set by the back end. An input item
// passes the queue, current command and output registers before any output item.
// rst is synchronous; no clearing pass. Either side may stall freely.
`timescale 1ns / 1ps

module substring_delimiter_splitter_core #(
  parameter int MAX_SEP = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [sds_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] in_byte
  input  logic                          s_tuser,   // [0] has_byte
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // [7:0] out_byte, [23:8] token_count
  output logic [sds_pkg::KIND_W-1:0]    m_tuser,   // [1:0] kind
  output logic                          m_tlast
);

  localparam int QW = MAX_SEP * 8 + $bits(sds_pkg::cmd_ctrl_t);

  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  logic [MAX_SEP*8-1:0] f_bytes;
  sds_pkg::cmd_ctrl_t   f_ctrl;
  logic [QW-1:0]        q_rdata;
  logic [MAX_SEP*8-1:0] b_bytes;
  sds_pkg::cmd_ctrl_t   b_ctrl;
  logic [7:0]           m_byte;
  logic [sds_pkg::CNT_W-1:0] m_count;

  sds_front #(.MAX_SEP(MAX_SEP)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_en        (cfg_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_byte       (s_tdata),
    .has_byte      (s_tuser),
    .end_of_string (s_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_bytes       (f_bytes),
    .q_ctrl        (f_ctrl)
  );

  sds_queue #(.DW(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_bytes, f_ctrl}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_bytes = q_rdata[QW-1 -: MAX_SEP*8];
  assign b_ctrl  = q_rdata[$bits(sds_pkg::cmd_ctrl_t)-1:0];

  sds_back #(.MAX_SEP(MAX_SEP)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_bytes (b_bytes),
    .q_ctrl  (b_ctrl),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_kind  (m_tuser),
    .m_byte  (m_byte),
    .m_count (m_count),
    .m_last  (m_tlast)
  );

  assign m_tdata = {m_count, m_byte};

endmodule

@@ design/sds_checker.sv @@
// Port checker for the substring delimiter splitter, bound to the top level.
// Uses sds_pkg and substring_delimiter_splitter_core_assert.svh.
`timescale 1ns / 1ps
`include "substring_delimiter_splitter_core_assert.svh"

module sds_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [23:0]                 m_tdata,
  input logic [sds_pkg::KIND_W-1:0]  m_tuser,
  input logic                        m_tlast
);

  `SDS_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "output item dropped")
  `SDS_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled data moved")
  `SDS_ASSERT(a_done_last, m_tvalid && m_tuser == sds_pkg::KIND_DONE |-> m_tlast, "done not last")
  `SDS_ASSERT(a_byte_zero, m_tvalid && m_tuser != sds_pkg::KIND_BYTE |-> m_tdata[7:0] == 8'd0, "stray byte")
  `SDS_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind substring_delimiter_splitter_core sds_checker u_sds_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ test/tb_top.sv @@
// Testbench for substring_delimiter_splitter_core: directed and random byte strings,
// checked item by item against a built-in splitter predictor.
// Depends on sds_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int SEP_BYTES   = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 6;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [sds_pkg::KIND_W-1:0] kind;
    logic [7:0]                 ch;
    logic [sds_pkg::CNT_W-1:0]  count;
    logic                       last;
  } split_rec_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_en = 1'b0;
  logic [sds_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                   cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [23:0]                   m_tdata;
  logic [sds_pkg::KIND_W-1:0]    m_tuser;
  logic                          m_tlast;

  // splitter predictor state
  logic [63:0]               sep_pat = sds_pkg::SEP_PATTERN_RESET;
  logic [3:0]                sep_len_reg = sds_pkg::SEP_LENGTH_RESET;
  logic [7:0]                held_win [SEP_BYTES];
  int                        held_n = 0;
  bit                        tok_open = 1'b0;
  logic [sds_pkg::CNT_W-1:0] tok_count = '0;
  split_rec_t                step_recs [sds_pkg::OUT_MAX];
  int                        step_n;

  split_rec_t  due_recs [$];
  int          bad_cnt = 0;
  int unsigned cycles = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  substring_delimiter_splitter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------- predictor ----------------

  function automatic int sep_len_eff();
    int l;
    l = sep_len_reg;
    if (l == 0) l = 1;
    if (l > SEP_BYTES) l = SEP_BYTES;
    return l;
  endfunction

  function automatic logic [7:0] sep_at(int i);
    return sep_pat[8*i +: 8];
  endfunction

  function automatic bit window_prefix(int len);
    for (int i = 0; i < held_n; i++) begin
      if (i >= len || held_win[i] != sep_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_rec(logic [sds_pkg::KIND_W-1:0] k, logic [7:0] ch,
                                  logic [sds_pkg::CNT_W-1:0] cnt);
    if (step_n < sds_pkg::OUT_MAX) begin
      step_recs[step_n] = '{k, ch, cnt, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void shift_out();
    add_rec(sds_pkg::KIND_BYTE, held_win[0], '0);
    tok_open = 1'b1;
    for (int i = 1; i < held_n && i < SEP_BYTES; i++) held_win[i-1] = held_win[i];
    held_n--;
    held_win[held_n] = '0;
  endfunction

  function automatic void bump_count();
    if (tok_count != '1) tok_count++;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < SEP_BYTES; i++) held_win[i] = '0;
    held_n = 0;
  endfunction

  // Works out the items caused by one input item and queues them.
  function automatic void split_step(logic [7:0] b, logic has, logic eos);
    int len;
    split_rec_t r;
    len = sep_len_eff();
    step_n = 0;
    if (has) begin
      if (held_n >= SEP_BYTES) shift_out();
      held_win[held_n] = b;
      held_n++;
      while (held_n > 0 && !window_prefix(len)) shift_out();
      if (held_n == len) begin
        if (tok_open) begin
          add_rec(sds_pkg::KIND_END, '0, '0);
          bump_count();
          tok_open = 1'b0;
        end
        clear_window();
      end
    end
    if (eos) begin
      while (held_n > 0) shift_out();
      if (tok_open) begin
        // full window at end: token end dropped, done item closes the token
        if (step_n + 2 <= sds_pkg::OUT_MAX) add_rec(sds_pkg::KIND_END, '0, '0);
        bump_count();
      end
      add_rec(sds_pkg::KIND_DONE, '0, tok_count);
      clear_window();
      tok_open = 1'b0;
      tok_count = '0;
    end
    for (int i = 0; i < step_n; i++) begin
      r = step_recs[i];
      r.last = (i == step_n - 1);
      due_recs.push_back(r);
    end
  endfunction

  // ---------------- checker ----------------

  always @(posedge clk) begin : check_out
    split_rec_t got;
    split_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast};
      if (due_recs.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= REPORT_MAX)
          $display("unexpected item: kind %0d byte %02h count %0d last %0b",
                   got.kind, got.ch, got.count, got.last);
      end else begin
        want = due_recs.pop_front();
        if (got.kind != want.kind || got.ch != want.ch || got.count != want.count ||
            got.last != want.last) begin
          bad_cnt++;
          if (bad_cnt <= REPORT_MAX)
            $display({"mismatch: exp kind %0d byte %02h count %0d last %0b,",
                      " got kind %0d byte %02h count %0d last %0b"},
                     want.kind, want.ch, want.count, want.last,
                     got.kind, got.ch, got.count, got.last);
        end
      end
    end
  end

  // ---------------- driving ----------------

  task automatic send_item(input logic [7:0] b, input logic has, input logic eos);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    split_step(b, has, eos);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Waits until every queued item has come out and the core has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (due_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sds_pkg::REG_IDX_W-1:0] idx, input logic [63:0] val);
    drain();
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    if (idx == sds_pkg::REG_SEP_PATTERN) sep_pat = val;
    else sep_len_reg = val[3:0];
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return sep_at($urandom_range(sep_len_eff() - 1));
    if (r < 80) return sep_at(0) ^ 8'h01;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [63:0] narrow_pattern();
    logic [63:0] p;
    for (int i = 0; i < SEP_BYTES; i++)
      p[8*i +: 8] = ($urandom_range(2) == 0) ? 8'($urandom_range(255))
                                              : 8'(8'h41 + $urandom_range(1));
    return p;
  endfunction

  // ---------------- tests ----------------

  // reset config (single comma): empty string, idle item, edge bytes, empty tokens
  task automatic test_default_sep();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h2C, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h2C, 1'b1, 1'b0);
    send_item(8'h2C, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  // eight-byte separator, seven held, mismatch plus end on one item
  task automatic test_full_window();
    write_reg(sds_pkg::REG_SEP_PATTERN, 64'h8877665544332211);
    write_reg(sds_pkg::REG_SEP_LENGTH, 64'd8);
    for (int i = 1; i <= 7; i++) send_item(8'(i * 8'h11), 1'b1, 1'b0);
    send_item(8'h99, 1'b1, 1'b1);
  endtask

  // held bytes re-checked after the length drops to zero (acts as one)
  task automatic test_length_change();
    write_reg(sds_pkg::REG_SEP_PATTERN, 64'h0000000000636261);
    write_reg(sds_pkg::REG_SEP_LENGTH, 64'd3);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    write_reg(sds_pkg::REG_SEP_LENGTH, 64'd0);
    send_item(8'h61, 1'b1, 1'b1);
  endtask

  // length above the window size acts as eight
  task automatic test_long_length();
    write_reg(sds_pkg::REG_SEP_PATTERN, '1);
    write_reg(sds_pkg::REG_SEP_LENGTH, 64'd15);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_random_phases();
    int items;
    int r;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 0;  recv_stall_pct = 0;
          write_reg(sds_pkg::REG_SEP_PATTERN, '0);
          write_reg(sds_pkg::REG_SEP_LENGTH, 64'd1);
        end
        1: begin
          send_gap_pct = 53; recv_stall_pct = 0;
          write_reg(sds_pkg::REG_SEP_PATTERN, narrow_pattern());
          write_reg(sds_pkg::REG_SEP_LENGTH, 64'd8);
        end
        2: begin
          send_gap_pct = 0;  recv_stall_pct = 53;
          write_reg(sds_pkg::REG_SEP_PATTERN, narrow_pattern());
          write_reg(sds_pkg::REG_SEP_LENGTH, 64'($urandom_range(7, 2)));
        end
        default: begin
          send_gap_pct = 9;  recv_stall_pct = 9;
          write_reg(sds_pkg::REG_SEP_PATTERN, {$urandom, $urandom});
          write_reg(sds_pkg::REG_SEP_LENGTH, 64'($urandom_range(15)));
        end
      endcase
      items = 0;
      while (items < 45) begin
        r = $urandom_range(99);
        if (r < 5) begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b0);
        end else if (r < 12) begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b1);
          items++;
        end else if (r < 25) begin
          len = sep_len_eff();
          for (int i = 0; i < len; i++) send_item(sep_at(i), 1'b1, 1'b0);
          items += len;
        end else begin
          send_item(pick_char(), 1'b1, ($urandom_range(9) == 0));
          items++;
        end
      end
    end
  endtask

  initial begin
    clear_window();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_sep();
    test_full_window();
    test_length_change();
    test_long_length();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);
    if (bad_cnt == 0 && due_recs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
